[hw/rtl/cpwid_pkg.sv]
`timescale 1ns / 1ps

package cpwid_pkg;

    // frame geometry
    localparam int FRAME_BITS_DEF = 24;
    localparam int FRAME_BITS_MIN = 8;
    localparam int FRAME_BITS_MAX = 32;

    // payload widths
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int SYMBOL_W = 2;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // reply word: type byte and 16-bit chain length
    localparam int REPLY_BITS = 24;
    localparam int LEN_W      = 16;
    localparam int IDX_W      = 5;
    localparam logic [7:0] WAIT_LAST = 8'hFF;

    // input modes
    localparam logic [MODE_W-1:0] MODE_MASTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLAVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    // output line and symbol codes
    localparam logic LINE_MASTER = 1'b0;
    localparam logic LINE_SLAVE  = 1'b1;

    localparam logic [SYMBOL_W-1:0] SYM_ZERO     = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_ONE      = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_END      = 2'd2;
    localparam logic [SYMBOL_W-1:0] SYM_PRESENCE = 2'd3;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_ONE_PULSE  = 3'd0;
    localparam logic [2:0] REG_ZERO_PULSE = 3'd1;
    localparam logic [2:0] REG_END_PULSE  = 3'd2;
    localparam logic [2:0] REG_TOLERANCE  = 3'd3;
    localparam logic [2:0] REG_OWN_COUNT  = 3'd4;
    localparam logic [2:0] REG_OWN_TYPE   = 3'd5;
    localparam logic [2:0] REG_COMMANDS   = 3'd6;
    localparam logic [2:0] REG_ACCEPTED   = 3'd7;

    typedef enum logic [1:0] {
        PH_MASTER,
        PH_WAIT,
        PH_SLAVE
    } t_phase;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_REQ,
        BR_ACK,
        BR_REPLY
    } t_burst;

endpackage

[hw/rtl/cpwid_in_if.sv]
`timescale 1ns / 1ps

interface cpwid_in_if;
    logic                           valid;
    logic                           ready;
    logic [cpwid_pkg::MODE_W-1:0]   mode;
    logic [cpwid_pkg::COUNT_W-1:0]  pulse_count;

    modport source (output valid, mode, pulse_count, input ready);
    modport sink   (input valid, mode, pulse_count, output ready);
endinterface

[hw/rtl/cpwid_out_if.sv]
`timescale 1ns / 1ps

interface cpwid_out_if;
    logic                            valid;
    logic                            ready;
    logic                            line;
    logic [cpwid_pkg::SYMBOL_W-1:0]  symbol;
    logic                            last;

    modport source (output valid, line, symbol, last, input ready);
    modport sink   (input valid, line, symbol, last, output ready);
endinterface

[hw/rtl/chained_pulse_width_id_responder.sv]
`timescale 1ns / 1ps

// channel   | dir | payload                         | handshake
// ----------+-----+---------------------------------+--------------------------
// i_in      | in  | mode[1:0], pulse_count[7:0]     | valid/ready
// o_out     | out | line, symbol[1:0], last         | valid/ready
// apb       | in  | paddr[4:0], pwdata[31:0]        | psel/penable, pready = 1
//
// an input transaction lands in the input register, is decoded in the next cycle
// and, if it produces symbols, loads the symbol sequencer, which drives the output
// from its registers at one symbol per cycle while o_out is ready (3, 4 or 25 per burst)
// transactions with no symbols pass at one per cycle; one with symbols waits in
// the input register only while the previous burst still drains
// synchronous active-low reset: listening to master, frame and counters cleared,
// registers zero except tolerance = 1; no clearing pass

module chained_pulse_width_id_responder #(
    parameter int FRAME_BITS = cpwid_pkg::FRAME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cpwid_in_if.sink                          i_in,
    cpwid_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cpwid_pkg::PADDR_W-1:0]     paddr,
    input  logic [cpwid_pkg::PDATA_W-1:0]     pwdata,
    output logic [cpwid_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int POS_W = $clog2(FRAME_BITS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

    // configuration registers
    logic [7:0]  r_one_cnt, r_zero_cnt, r_end_cnt, r_tol, r_own_type;
    logic [15:0] r_own_cnt, r_cmd, r_acc;

    // input register
    logic                            r_in_vld;
    logic [cpwid_pkg::MODE_W-1:0]    r_mode;
    logic [cpwid_pkg::COUNT_W-1:0]   r_count;

    // protocol state
    cpwid_pkg::t_phase       r_phase, n_phase;
    logic [FRAME_BITS-1:0]   r_frame, n_frame;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [7:0]              r_wait, n_wait;

    // symbol sequencer
    logic                            r_busy;
    cpwid_pkg::t_burst               r_kind;
    logic [cpwid_pkg::REPLY_BITS-1:0] r_word;
    logic [cpwid_pkg::IDX_W-1:0]     r_idx;

    // decode of the held transaction
    cpwid_pkg::t_burst                c_kind;
    logic [cpwid_pkg::REPLY_BITS-1:0] c_word;
    logic                             c_fire;
    logic                             c_emit_free;
    logic                             c_out_take;
    logic                             c_wr;
    logic [31:0]                      c_ext;
    logic [7:0]                       c_type;
    logic [cpwid_pkg::LEN_W-1:0]      c_len;
    logic                             c_trust;
    logic                             c_one, c_zero, c_end;
    logic [POS_W-1:0]                 c_pos, c_bidx, c_pos_inc;

    function automatic logic near(input logic [7:0] cnt, input logic [7:0] nom,
                                  input logic [7:0] tol);
        logic [7:0] d;
        d = (cnt > nom) ? cnt - nom : nom - cnt;
        return d < tol;
    endfunction

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_cnt  <= '0;
            r_zero_cnt <= '0;
            r_end_cnt  <= '0;
            r_tol      <= 8'd1;
            r_own_cnt  <= '0;
            r_own_type <= '0;
            r_cmd      <= '0;
            r_acc      <= '0;
        end else if (c_wr) begin
            unique case (paddr[4:2])
                cpwid_pkg::REG_ONE_PULSE:  r_one_cnt  <= pwdata[7:0];
                cpwid_pkg::REG_ZERO_PULSE: r_zero_cnt <= pwdata[7:0];
                cpwid_pkg::REG_END_PULSE:  r_end_cnt  <= pwdata[7:0];
                cpwid_pkg::REG_TOLERANCE:  r_tol      <= pwdata[7:0];
                cpwid_pkg::REG_OWN_COUNT:  r_own_cnt  <= pwdata[15:0];
                cpwid_pkg::REG_OWN_TYPE:   r_own_type <= pwdata[7:0];
                cpwid_pkg::REG_COMMANDS:   r_cmd      <= pwdata[15:0];
                cpwid_pkg::REG_ACCEPTED:   r_acc      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cpwid_pkg::REG_ONE_PULSE:  prdata = {24'd0, r_one_cnt};
            cpwid_pkg::REG_ZERO_PULSE: prdata = {24'd0, r_zero_cnt};
            cpwid_pkg::REG_END_PULSE:  prdata = {24'd0, r_end_cnt};
            cpwid_pkg::REG_TOLERANCE:  prdata = {24'd0, r_tol};
            cpwid_pkg::REG_OWN_COUNT:  prdata = {16'd0, r_own_cnt};
            cpwid_pkg::REG_OWN_TYPE:   prdata = {24'd0, r_own_type};
            cpwid_pkg::REG_COMMANDS:   prdata = {16'd0, r_cmd};
            cpwid_pkg::REG_ACCEPTED:   prdata = {16'd0, r_acc};
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input stage
    // a transaction without symbols never waits for the sequencer
    assign c_out_take  = o_out.valid && o_out.ready;
    assign c_emit_free = !r_busy || (c_out_take && o_out.last);
    assign c_fire      = r_in_vld && ((c_kind == cpwid_pkg::BR_NONE) || c_emit_free);
    assign i_in.ready  = !r_in_vld || c_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode  <= i_in.mode;
            r_count <= i_in.pulse_count;
        end
    end

    // ---------------------------------------------------------------- frame decode
    // left-align the frame in 32 bits: type is the top byte, length the next 16,
    // missing low bits read as zero for short frames
    assign c_ext   = 32'(r_frame) << (32 - FRAME_BITS);
    assign c_type  = c_ext[31:24];
    assign c_trust = (c_type == r_acc[7:0]) || (c_type == r_acc[15:8]);
    assign c_len   = (c_trust ? c_ext[23:8] : 16'd0) + r_own_cnt;
    assign c_word  = {r_own_type, c_len};

    assign c_one  = near(r_count, r_one_cnt, r_tol);
    assign c_zero = near(r_count, r_zero_cnt, r_tol);
    assign c_end  = near(r_count, r_end_cnt, r_tol);

    // first slave pulse after the request starts a fresh frame
    assign c_pos     = (r_phase == cpwid_pkg::PH_WAIT) ? '0 : r_pos;
    assign c_bidx    = POS_LAST - c_pos;
    assign c_pos_inc = (c_pos == POS_LAST) ? '0 : c_pos + 1'b1;

    // next state of the protocol machine
    always_comb begin
        n_phase = r_phase;
        n_frame = r_frame;
        n_pos   = r_pos;
        n_wait  = r_wait;
        c_kind  = cpwid_pkg::BR_NONE;
        case (r_mode)
            cpwid_pkg::MODE_MASTER: begin
                if (r_phase == cpwid_pkg::PH_MASTER) begin
                    if (c_one) begin
                        n_frame[c_bidx] = 1'b1;
                        n_pos           = c_pos_inc;
                    end else if (c_zero) begin
                        n_frame[c_bidx] = 1'b0;
                        n_pos           = c_pos_inc;
                    end else if (c_end) begin
                        n_pos = '0;
                        if (c_type == r_cmd[7:0]) begin
                            // request: presence, forward 1,0,end and wait for slave
                            c_kind  = cpwid_pkg::BR_REQ;
                            n_frame = '0;
                            n_wait  = '0;
                            n_phase = cpwid_pkg::PH_WAIT;
                        end else if (c_type == r_cmd[15:8]) begin
                            c_kind = cpwid_pkg::BR_ACK;
                        end
                    end
                end
            end
            cpwid_pkg::MODE_SLAVE: begin
                if (r_phase != cpwid_pkg::PH_MASTER) begin
                    n_phase = cpwid_pkg::PH_SLAVE;
                    n_pos   = c_pos;
                    if (c_one) begin
                        n_frame[c_bidx] = 1'b1;
                        n_pos           = c_pos_inc;
                    end else if (c_zero) begin
                        n_frame[c_bidx] = 1'b0;
                        n_pos           = c_pos_inc;
                    end else if (c_end) begin
                        c_kind  = cpwid_pkg::BR_REPLY;
                        n_frame = '0;
                        n_pos   = '0;
                        n_wait  = '0;
                        n_phase = cpwid_pkg::PH_MASTER;
                    end
                end
            end
            cpwid_pkg::MODE_TICK: begin
                if (r_phase == cpwid_pkg::PH_WAIT) begin
                    if (r_wait == cpwid_pkg::WAIT_LAST) begin
                        // slave silent too long: reply with own length only
                        c_kind  = cpwid_pkg::BR_REPLY;
                        n_frame = '0;
                        n_pos   = '0;
                        n_wait  = '0;
                        n_phase = cpwid_pkg::PH_MASTER;
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cpwid_pkg::PH_MASTER;
            r_frame <= '0;
            r_pos   <= '0;
            r_wait  <= '0;
        end else if (c_fire) begin
            r_phase <= n_phase;
            r_frame <= n_frame;
            r_pos   <= n_pos;
            r_wait  <= n_wait;
        end
    end

    // ---------------------------------------------------------------- symbol sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= cpwid_pkg::BR_NONE;
            r_idx  <= '0;
        end else if (c_fire && (c_kind != cpwid_pkg::BR_NONE)) begin
            r_busy <= 1'b1;
            r_kind <= c_kind;
            r_idx  <= '0;
        end else if (c_out_take) begin
            if (o_out.last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire && (c_kind == cpwid_pkg::BR_REPLY)) begin
            r_word <= c_word;
        end
    end

    // symbol of the current burst position
    always_comb begin
        o_out.valid  = r_busy;
        o_out.line   = cpwid_pkg::LINE_MASTER;
        o_out.symbol = cpwid_pkg::SYM_END;
        o_out.last   = 1'b0;
        case (r_kind)
            cpwid_pkg::BR_REQ: begin
                case (r_idx)
                    5'd0: o_out.symbol = cpwid_pkg::SYM_PRESENCE;
                    5'd1: begin
                        o_out.line   = cpwid_pkg::LINE_SLAVE;
                        o_out.symbol = cpwid_pkg::SYM_ONE;
                    end
                    5'd2: begin
                        o_out.line   = cpwid_pkg::LINE_SLAVE;
                        o_out.symbol = cpwid_pkg::SYM_ZERO;
                    end
                    default: begin
                        o_out.line = cpwid_pkg::LINE_SLAVE;
                        o_out.last = 1'b1;
                    end
                endcase
            end
            cpwid_pkg::BR_ACK: begin
                if (r_idx < 5'd2) begin
                    o_out.symbol = cpwid_pkg::SYM_ONE;
                end else begin
                    o_out.last = 1'b1;
                end
            end
            cpwid_pkg::BR_REPLY: begin
                if (r_idx < 5'(cpwid_pkg::REPLY_BITS)) begin
                    o_out.symbol = r_word[5'(cpwid_pkg::REPLY_BITS - 1) - r_idx]
                                   ? cpwid_pkg::SYM_ONE : cpwid_pkg::SYM_ZERO;
                end else begin
                    o_out.last = 1'b1;
                end
            end
            default: o_out.last = 1'b1;
        endcase
    end

`ifndef SYNTHESIS
    // a burst never stops before its last symbol
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_out_take && !o_out.last |=> o_out.valid)
        else $error("burst broke off before last symbol");

    // while waiting for the slave the frame stays cleared
    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cpwid_pkg::PH_WAIT) |-> (r_frame == '0))
        else $error("frame not clear while waiting");

    // a held transaction stays put until decoded
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !c_fire |=> r_in_vld && $stable(r_mode) && $stable(r_count))
        else $error("held transaction lost");

    // the sequencer never runs past the reply length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= 5'(cpwid_pkg::REPLY_BITS)))
        else $error("sequencer index out of range");

    // no new burst is loaded over one still draining
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_fire && (c_kind != cpwid_pkg::BR_NONE) |-> !r_busy || (c_out_take && o_out.last))
        else $error("burst overwritten");
`endif

endmodule
